[rtl/ccw_pkg.sv]
// Shared types and constants for the CUBIC congestion window block.
`default_nettype none

package ccw_pkg;

   // Window format: unsigned Q24.16
   localparam int WIN_INT_BITS = 24;
   localparam int FRAC_BITS    = 16;
   localparam int WIN_BITS     = WIN_INT_BITS + FRAC_BITS;

   localparam logic [WIN_BITS-1:0] WIN_MAX = '1;
   localparam logic [WIN_BITS-1:0] WIN_ONE = 40'h00_0001_0000;
   localparam logic [WIN_BITS-1:0] WIN_TWO = 40'h00_0002_0000;

   // Saturation limits of the multiply/divide unit
   localparam logic [63:0] CAP_BIG = 64'h4000_0000_0000_0000;
   localparam logic [63:0] CAP_Q16 = 64'h0010_0000_0000_0000;
   localparam logic [63:0] CAP_WIN = 64'h0000_00FF_FFFF_FFFF;
   localparam logic [63:0] CAP_ALL = 64'hFFFF_FFFF_FFFF_FFFF;

   // Time conversion
   localparam logic [63:0] USEC_PER_SEC = 64'd1000000;
   localparam logic [63:0] T_LIMIT_US   = 64'd4096000000;
   localparam logic [31:0] TIME_SCALE   = 32'h0010_0000;
   localparam logic [31:0] Q16_ONE      = 32'h0001_0000;

   // Congestion control phases
   localparam logic [1:0] PH_SLOW  = 2'd0;
   localparam logic [1:0] PH_AVOID = 2'd1;
   localparam logic [1:0] PH_RECOV = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_BETA  = 2'd0;
   localparam logic [1:0] CSR_SCALE = 2'd1;
   localparam logic [1:0] CSR_IWIN  = 2'd2;
   localparam logic [1:0] CSR_ITHR  = 2'd3;

   // Register reset values
   localparam logic [15:0] BETA_RESET  = 16'd45875;
   localparam logic [15:0] SCALE_RESET = 16'd26214;
   localparam logic [15:0] IWIN_RESET  = 16'd10;
   localparam logic [23:0] ITHR_RESET  = 24'd65535;

   // Multiply/divide unit modes
   typedef enum logic [1:0] {
      MD_DIV,
      MD_SHR,
      MD_RAW
   } md_mode_type;

   // One multiply/divide command: floor(a*b/d), or (a*b)>>16, or a*b, capped
   typedef struct packed {
      md_mode_type  mode;
      logic [63:0]  a;
      logic [31:0]  b;
      logic [63:0]  d;
      logic [63:0]  cap;
   } md_cmd_type;

endpackage

`default_nettype wire

[rtl/ccw_muldiv.sv]
// Bit-serial multiply then restoring divide unit with saturation.
`default_nettype none

module ccw_muldiv (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire ccw_pkg::md_cmd_type cmd,
   output logic                    done,
   output logic [63:0]             result
);

   typedef enum logic [1:0] {
      M_IDLE,
      M_MUL,
      M_DIV,
      M_SAT
   } md_state_type;

   md_state_type         state_ff;
   ccw_pkg::md_mode_type mode_ff;
   logic [95:0]          mcand_ff;
   logic [31:0]          mplier_ff;
   logic [95:0]          acc_ff;
   logic [63:0]          div_ff;
   logic [63:0]          cap_ff;
   logic [95:0]          quo_ff;
   logic [63:0]          rem_ff;
   logic [6:0]           cnt_ff;
   logic                 done_ff;
   logic [63:0]          result_ff;

   logic [64:0]          rem_shift;
   logic                 rem_fit;
   logic [64:0]          rem_sub;
   logic [95:0]          sat_value;
   logic [63:0]          sat_res;

   // Divide step and final saturation
   always_comb begin
      rem_shift = {rem_ff, acc_ff[95]};
      rem_fit   = rem_shift >= {1'b0, div_ff};
      rem_sub   = rem_shift - {1'b0, div_ff};
      case (mode_ff)
         ccw_pkg::MD_DIV: sat_value = quo_ff;
         ccw_pkg::MD_SHR: sat_value = {16'd0, acc_ff[95:16]};
         default:         sat_value = acc_ff;
      endcase
      sat_res = (sat_value > {32'd0, cap_ff}) ? cap_ff : sat_value[63:0];
   end

   // Sequence: shift-add multiply, then in divide mode one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            M_IDLE: begin
               if (start) begin
                  mode_ff   <= cmd.mode;
                  mcand_ff  <= {32'd0, cmd.a};
                  mplier_ff <= cmd.b;
                  acc_ff    <= '0;
                  div_ff    <= cmd.d;
                  cap_ff    <= cmd.cap;
                  state_ff  <= M_MUL;
               end
            end
            M_MUL: begin
               if (mplier_ff == 32'd0) begin
                  if (mode_ff == ccw_pkg::MD_DIV) begin
                     if (div_ff == 64'd0) begin
                        quo_ff   <= '1;
                        state_ff <= M_SAT;
                     end else begin
                        quo_ff   <= '0;
                        rem_ff   <= '0;
                        cnt_ff   <= 7'd95;
                        state_ff <= M_DIV;
                     end
                  end else begin
                     state_ff <= M_SAT;
                  end
               end else begin
                  if (mplier_ff[0]) begin
                     acc_ff <= acc_ff + mcand_ff;
                  end
                  mcand_ff  <= {mcand_ff[94:0], 1'b0};
                  mplier_ff <= {1'b0, mplier_ff[31:1]};
               end
            end
            M_DIV: begin
               acc_ff <= {acc_ff[94:0], 1'b0};
               if (rem_fit) begin
                  rem_ff <= rem_sub[63:0];
               end else begin
                  rem_ff <= rem_shift[63:0];
               end
               quo_ff <= {quo_ff[94:0], rem_fit};
               if (cnt_ff == 7'd0) begin
                  state_ff <= M_SAT;
               end else begin
                  cnt_ff <= cnt_ff - 7'd1;
               end
            end
            M_SAT: begin
               result_ff <= sat_res;
               done_ff   <= 1'b1;
               state_ff  <= M_IDLE;
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

[rtl/cubic_congestion_window.sv]
// CUBIC congestion window: event sequencer, state registers and result register.
//
// Requests carry an acknowledgement or loss event with a microsecond
// timestamp on req_*; one result per request leaves on rsp_* holding the
// congestion window, phase, peak window and loss/recovery counters.
// Registers are written on csr_* (always ready). The user must write them
// only while the block is idle; the block itself does not enforce this.
// One request is worked at a time; req_stall is high from acceptance until
// its result is loaded into the output register. Zero-packet
// acknowledgements, slow start and fast recovery do without the shared
// bit-serial multiply/divide unit (one multiplier bit, then one of 96
// quotient bits, per cycle); a loss and a congestion-avoidance
// acknowledgement use it, and the first one of a cubic epoch also uses it
// for K in the 21-step cube root.
// The result register holds its value while rsp_stall is high, and the
// next request may be accepted meanwhile; its result waits until the
// previous one is taken. Synchronous reset loads the register defaults,
// an initial window of 10 packets and slow start, with no result pending.
`default_nettype none

module cubic_congestion_window (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [15:0] req_acked_packets,
   input  wire logic        req_timeout_loss,
   input  wire logic [63:0] req_time_us,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [23:0]      rsp_window_packets,
   output logic [39:0]      rsp_window_fixed,
   output logic [1:0]       rsp_phase,
   output logic [39:0]      rsp_peak_window,
   output logic [31:0]      rsp_loss_count,
   output logic [31:0]      rsp_recovery_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_data
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOSS,
      S_KQ,
      S_CB_SQ,
      S_CB_CU,
      S_TIME,
      S_DSQ,
      S_DCU,
      S_TERM,
      S_RATIO,
      S_WT,
      S_INC,
      S_FIN,
      S_EMIT
   } seq_state_type;

   // Saturating window add
   function automatic logic [39:0] sat_add(input logic [39:0] x, input logic [39:0] y);
      logic [40:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[40] ? ccw_pkg::WIN_MAX : s[39:0];
   endfunction

   function automatic ccw_pkg::md_cmd_type make_cmd(
      input ccw_pkg::md_mode_type mode,
      input logic [63:0] a,
      input logic [31:0] b,
      input logic [63:0] d,
      input logic [63:0] cap
   );
      ccw_pkg::md_cmd_type c;
      c.mode = mode;
      c.a    = a;
      c.b    = b;
      c.d    = d;
      c.cap  = cap;
      return c;
   endfunction

   seq_state_type       state_ff;
   logic                md_wait_ff;
   logic                md_start_ff;
   ccw_pkg::md_cmd_type md_cmd_ff;
   logic                md_done;
   logic [63:0]         md_result;

   // Configuration
   logic [15:0] beta_ff;
   logic [15:0] scale_ff;
   logic [15:0] iwin_ff;

   // Architectural state
   logic [39:0] window_ff;
   logic [39:0] threshold_ff;
   logic [1:0]  phase_ff;
   logic [39:0] wbl_ff;
   logic [31:0] k_ff;
   logic [63:0] epoch_ff;
   logic        epoch_valid_ff;
   logic [39:0] peak_ff;
   logic [31:0] losses_ff;
   logic [31:0] recov_ff;
   logic        seeded_ff;

   // Request and working registers
   logic        timeout_ff;
   logic [15:0] acked_ff;
   logic [63:0] time_ff;
   logic [63:0] root_x_ff;
   logic [3:0]  s_ff;
   logic [20:0] root_ff;
   logic [4:0]  bit_ff;
   logic [63:0] sq_ff;
   logic [31:0] t20_ff;
   logic [63:0] dpow_ff;
   logic [39:0] wc_ff;
   logic [39:0] ratio_ff;
   logic [39:0] wt_ff;

   // Result register
   logic        rsp_valid_ff;
   logic [23:0] rsp_packets_ff;
   logic [39:0] rsp_fixed_ff;
   logic [1:0]  rsp_phase_ff;
   logic [39:0] rsp_peak_ff;
   logic [31:0] rsp_losses_ff;
   logic [31:0] rsp_recov_ff;

   logic        req_take;
   logic        rsp_free;
   logic [39:0] req_acked_fixed;
   logic [39:0] acked_fixed;
   logic [39:0] ss_win;
   logic [39:0] init_win_fixed;
   logic [15:0] scale_eff;
   logic [16:0] one_minus_beta;
   logic [63:0] elapsed;
   logic [3:0]  s_cnt;
   logic [5:0]  x_shift;
   logic [20:0] cand;
   logic [20:0] root_next;
   logic [32:0] k_wide;
   logic [31:0] k_next;
   logic [31:0] d_abs;
   logic [27:0] d16;
   logic [64:0] w16;
   logic [39:0] wc_next;
   logic [39:0] target;
   logic [39:0] th_next;
   logic [39:0] win_floor;
   logic [23:0] win_packets;

   ccw_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (md_start_ff),
      .cmd    (md_cmd_ff),
      .done   (md_done),
      .result (md_result)
   );

   // Datapath helpers around the shared unit
   always_comb begin
      req_take        = req_valid && !req_stall;
      rsp_free        = !rsp_valid_ff || !rsp_stall;
      req_acked_fixed = {8'd0, req_acked_packets, 16'd0};
      acked_fixed     = {8'd0, acked_ff, 16'd0};
      ss_win          = sat_add(window_ff, req_acked_fixed);
      init_win_fixed  = {8'd0, ((iwin_ff == 16'd0) ? 16'd1 : iwin_ff), 16'd0};
      scale_eff       = (scale_ff == 16'd0) ? 16'd1 : scale_ff;
      one_minus_beta  = 17'h10000 - {1'b0, beta_ff};
      elapsed         = time_ff - epoch_ff;

      // Normalize K's cube-root argument by whole groups of three bits
      s_cnt = 4'd0;
      for (int i = 0; i < 11; i++) begin
         if ((md_result >> (19 + 3 * i)) != 64'd0) begin
            s_cnt = s_cnt + 4'd1;
         end
      end
      x_shift = 6'd44 - ({2'd0, s_cnt} + {1'b0, s_cnt, 1'b0});

      cand      = root_ff | (21'd1 << bit_ff);
      root_next = (md_result <= root_x_ff) ? cand : root_ff;
      k_wide    = {12'd0, root_next} << s_ff;
      k_next    = k_wide[32] ? 32'hFFFF_FFFF : k_wide[31:0];

      d_abs = (t20_ff >= k_ff) ? (t20_ff - k_ff) : (k_ff - t20_ff);
      d16   = d_abs[31:4];

      // Cubic target from W_max and the cubic term
      if (t20_ff < k_ff) begin
         w16 = ({25'd0, wbl_ff} > {1'b0, md_result}) ?
               ({25'd0, wbl_ff} - {1'b0, md_result}) : 65'd0;
      end else begin
         w16 = {25'd0, wbl_ff} + {1'b0, md_result};
      end
      if (w16 < {25'd0, ccw_pkg::WIN_ONE}) begin
         wc_next = ccw_pkg::WIN_ONE;
      end else if (w16 > {25'd0, ccw_pkg::WIN_MAX}) begin
         wc_next = ccw_pkg::WIN_MAX;
      end else begin
         wc_next = w16[39:0];
      end

      target    = (wc_ff > wt_ff) ? wc_ff : wt_ff;
      th_next   = (md_result[39:0] < ccw_pkg::WIN_TWO) ? ccw_pkg::WIN_TWO : md_result[39:0];
      win_floor = (window_ff < ccw_pkg::WIN_ONE) ? ccw_pkg::WIN_ONE : window_ff;
      win_packets = (window_ff[39:16] == 24'd0) ? 24'd1 : window_ff[39:16];
   end

   // Sequencer, state registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         md_wait_ff     <= 1'b0;
         md_start_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         beta_ff        <= ccw_pkg::BETA_RESET;
         scale_ff       <= ccw_pkg::SCALE_RESET;
         iwin_ff        <= ccw_pkg::IWIN_RESET;
         window_ff      <= {8'd0, ccw_pkg::IWIN_RESET, 16'd0};
         threshold_ff   <= {ccw_pkg::ITHR_RESET, 16'd0};
         phase_ff       <= ccw_pkg::PH_SLOW;
         wbl_ff         <= '0;
         k_ff           <= '0;
         epoch_ff       <= '0;
         epoch_valid_ff <= 1'b0;
         peak_ff        <= {8'd0, ccw_pkg::IWIN_RESET, 16'd0};
         losses_ff      <= '0;
         recov_ff       <= '0;
         seeded_ff      <= 1'b0;
      end else begin
         // Make the start pulse a one-cycle strobe
         if (md_start_ff) begin
            md_start_ff <= 1'b0;
         end

         // Drop the result once taken, unless a new one is loaded now
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         // Register writes; reseed the window, peak and threshold before the first request
         if (csr_valid) begin
            case (csr_index)
               ccw_pkg::CSR_BETA:  beta_ff  <= csr_data[15:0];
               ccw_pkg::CSR_SCALE: scale_ff <= csr_data[15:0];
               ccw_pkg::CSR_IWIN: begin
                  iwin_ff <= csr_data[15:0];
                  if (!seeded_ff) begin
                     window_ff <= {8'd0, ((csr_data[15:0] == 16'd0) ? 16'd1 : csr_data[15:0]),
                                   16'd0};
                     peak_ff   <= {8'd0, ((csr_data[15:0] == 16'd0) ? 16'd1 : csr_data[15:0]),
                                   16'd0};
                  end
               end
               ccw_pkg::CSR_ITHR: begin
                  if (!seeded_ff) begin
                     threshold_ff <= {csr_data, 16'd0};
                  end
               end
               default: ;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  seeded_ff  <= 1'b1;
                  timeout_ff <= req_timeout_loss;
                  acked_ff   <= req_acked_packets;
                  time_ff    <= req_time_us;
                  if (req_op) begin
                     state_ff <= S_LOSS;
                  end else if (req_acked_packets == 16'd0) begin
                     state_ff <= S_EMIT;
                  end else begin
                     case (phase_ff)
                        ccw_pkg::PH_SLOW: begin
                           window_ff <= ss_win;
                           if (ss_win >= threshold_ff) begin
                              phase_ff       <= ccw_pkg::PH_AVOID;
                              epoch_valid_ff <= 1'b0;
                           end
                           state_ff <= S_FIN;
                        end
                        ccw_pkg::PH_RECOV: begin
                           window_ff      <= ss_win;
                           phase_ff       <= ccw_pkg::PH_AVOID;
                           recov_ff       <= recov_ff + 32'd1;
                           epoch_valid_ff <= 1'b0;
                           state_ff       <= S_FIN;
                        end
                        default: begin
                           if (!epoch_valid_ff) begin
                              epoch_ff       <= req_time_us;
                              epoch_valid_ff <= 1'b1;
                              state_ff       <= S_KQ;
                           end else begin
                              state_ff <= S_TIME;
                           end
                        end
                     endcase
                  end
               end
            end

            // Multiplicative decrease; a timeout loss instead restarts slow start from the initial window
            S_LOSS: begin
               if (!md_wait_ff) begin
                  md_cmd_ff   <= make_cmd(ccw_pkg::MD_SHR, {24'd0, window_ff}, {16'd0, beta_ff},
                                          64'd0, ccw_pkg::CAP_WIN);
                  md_start_ff <= 1'b1;
                  md_wait_ff  <= 1'b1;
               end else if (md_done) begin
                  md_wait_ff     <= 1'b0;
                  losses_ff      <= losses_ff + 32'd1;
                  wbl_ff         <= window_ff;
                  threshold_ff   <= th_next;
                  epoch_valid_ff <= 1'b0;
                  if (timeout_ff) begin
                     window_ff <= init_win_fixed;
                     phase_ff  <= ccw_pkg::PH_SLOW;
                  end else begin
                     window_ff <= th_next;
                     phase_ff  <= ccw_pkg::PH_RECOV;
                  end
                  state_ff <= S_EMIT;
               end
            end

            // K: cube-root argument W_max*(1-beta)/C
            S_KQ: begin
               if (!md_wait_ff) begin
                  md_cmd_ff   <= make_cmd(ccw_pkg::MD_DIV, {24'd0, wbl_ff},
                                          {15'd0, one_minus_beta}, {48'd0, scale_eff},
                                          ccw_pkg::CAP_Q16);
                  md_start_ff <= 1'b1;
                  md_wait_ff  <= 1'b1;
               end else if (md_done) begin
                  md_wait_ff <= 1'b0;
                  if (md_result >= ccw_pkg::CAP_Q16) begin
                     k_ff     <= 32'hFFFF_FFFF;
                     state_ff <= S_TIME;
                  end else begin
                     root_x_ff <= md_result << x_shift;
                     s_ff      <= s_cnt;
                     root_ff   <= '0;
                     bit_ff    <= 5'd20;
                     state_ff  <= S_CB_SQ;
                  end
               end
            end

            // Cube root, one result bit per trial: square the candidate
            S_CB_SQ: begin
               if (!md_wait_ff) begin
                  md_cmd_ff   <= make_cmd(ccw_pkg::MD_RAW, {43'd0, cand}, {11'd0, cand},
                                          64'd0, ccw_pkg::CAP_ALL);
                  md_start_ff <= 1'b1;
                  md_wait_ff  <= 1'b1;
               end else if (md_done) begin
                  md_wait_ff <= 1'b0;
                  sq_ff      <= md_result;
                  state_ff   <= S_CB_CU;
               end
            end

            // Cube the candidate and keep the bit if it fits
            S_CB_CU: begin
               if (!md_wait_ff) begin
                  md_cmd_ff   <= make_cmd(ccw_pkg::MD_RAW, sq_ff, {11'd0, cand},
                                          64'd0, ccw_pkg::CAP_ALL);
                  md_start_ff <= 1'b1;
                  md_wait_ff  <= 1'b1;
               end else if (md_done) begin
                  md_wait_ff <= 1'b0;
                  root_ff    <= root_next;
                  if (bit_ff == 5'd0) begin
                     k_ff     <= k_next;
                     state_ff <= S_TIME;
                  end else begin
                     bit_ff   <= bit_ff - 5'd1;
                     state_ff <= S_CB_SQ;
                  end
               end
            end

            // Elapsed time in Q12.20 seconds
            S_TIME: begin
               if (!md_wait_ff) begin
                  if (elapsed >= ccw_pkg::T_LIMIT_US) begin
                     t20_ff   <= 32'hFFFF_FFFF;
                     state_ff <= S_DSQ;
                  end else begin
                     md_cmd_ff   <= make_cmd(ccw_pkg::MD_DIV, elapsed, ccw_pkg::TIME_SCALE,
                                             ccw_pkg::USEC_PER_SEC, ccw_pkg::CAP_BIG);
                     md_start_ff <= 1'b1;
                     md_wait_ff  <= 1'b1;
                  end
               end else if (md_done) begin
                  md_wait_ff <= 1'b0;
                  t20_ff     <= md_result[31:0];
                  state_ff   <= S_DSQ;
               end
            end

            S_DSQ: begin
               if (!md_wait_ff) begin
                  md_cmd_ff   <= make_cmd(ccw_pkg::MD_SHR, {36'd0, d16}, {4'd0, d16},
                                          64'd0, ccw_pkg::CAP_BIG);
                  md_start_ff <= 1'b1;
                  md_wait_ff  <= 1'b1;
               end else if (md_done) begin
                  md_wait_ff <= 1'b0;
                  dpow_ff    <= md_result;
                  state_ff   <= S_DCU;
               end
            end

            S_DCU: begin
               if (!md_wait_ff) begin
                  md_cmd_ff   <= make_cmd(ccw_pkg::MD_SHR, dpow_ff, {4'd0, d16},
                                          64'd0, ccw_pkg::CAP_BIG);
                  md_start_ff <= 1'b1;
                  md_wait_ff  <= 1'b1;
               end else if (md_done) begin
                  md_wait_ff <= 1'b0;
                  dpow_ff    <= md_result;
                  state_ff   <= S_TERM;
               end
            end

            // Scale by C and form the cubic target
            S_TERM: begin
               if (!md_wait_ff) begin
                  md_cmd_ff   <= make_cmd(ccw_pkg::MD_SHR, dpow_ff, {16'd0, scale_eff},
                                          64'd0, ccw_pkg::CAP_BIG);
                  md_start_ff <= 1'b1;
                  md_wait_ff  <= 1'b1;
               end else if (md_done) begin
                  md_wait_ff <= 1'b0;
                  wc_ff      <= wc_next;
                  state_ff   <= S_RATIO;
               end
            end

            // acked / window
            S_RATIO: begin
               if (!md_wait_ff) begin
                  md_cmd_ff   <= make_cmd(ccw_pkg::MD_DIV, {24'd0, acked_fixed},
                                          ccw_pkg::Q16_ONE, {24'd0, window_ff},
                                          ccw_pkg::CAP_WIN);
                  md_start_ff <= 1'b1;
                  md_wait_ff  <= 1'b1;
               end else if (md_done) begin
                  md_wait_ff <= 1'b0;
                  ratio_ff   <= md_result[39:0];
                  state_ff   <= S_WT;
               end
            end

            // TCP-friendly estimate
            S_WT: begin
               if (!md_wait_ff) begin
                  md_cmd_ff   <= make_cmd(ccw_pkg::MD_SHR, {24'd0, wbl_ff}, {16'd0, beta_ff},
                                          64'd0, ccw_pkg::CAP_WIN);
                  md_start_ff <= 1'b1;
                  md_wait_ff  <= 1'b1;
               end else if (md_done) begin
                  md_wait_ff <= 1'b0;
                  wt_ff      <= sat_add(md_result[39:0], ratio_ff);
                  state_ff   <= S_INC;
               end
            end

            // Advance the window toward the larger target, or by acked / window when not below it
            S_INC: begin
               if (!md_wait_ff) begin
                  if (target > window_ff) begin
                     md_cmd_ff   <= make_cmd(ccw_pkg::MD_DIV, {24'd0, target - window_ff},
                                             acked_fixed[31:0], {24'd0, window_ff},
                                             ccw_pkg::CAP_WIN);
                     md_start_ff <= 1'b1;
                     md_wait_ff  <= 1'b1;
                  end else begin
                     window_ff <= sat_add(window_ff, ratio_ff);
                     state_ff  <= S_FIN;
                  end
               end else if (md_done) begin
                  md_wait_ff <= 1'b0;
                  window_ff  <= sat_add(window_ff, md_result[39:0]);
                  state_ff   <= S_FIN;
               end
            end

            // Floor the window at one packet and track the peak
            S_FIN: begin
               window_ff <= win_floor;
               if (win_floor > peak_ff) begin
                  peak_ff <= win_floor;
               end
               state_ff <= S_EMIT;
            end

            // Load the result register once it is free
            S_EMIT: begin
               if (rsp_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_packets_ff <= win_packets;
                  rsp_fixed_ff   <= window_ff;
                  rsp_phase_ff   <= phase_ff;
                  rsp_peak_ff    <= peak_ff;
                  rsp_losses_ff  <= losses_ff;
                  rsp_recov_ff   <= recov_ff;
                  state_ff       <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_window_packets = rsp_packets_ff;
   assign rsp_window_fixed   = rsp_fixed_ff;
   assign rsp_phase          = rsp_phase_ff;
   assign rsp_peak_window    = rsp_peak_ff;
   assign rsp_loss_count     = rsp_losses_ff;
   assign rsp_recovery_count = rsp_recov_ff;

endmodule

`default_nettype wire
